FILE: rtl/blf_pkg.sv
// ----------------------------------------------------------------------------
// blf_pkg
// Shared types and constants of the blank aware line folder.
// ----------------------------------------------------------------------------
package blf_pkg;

  localparam int          DEPTH_DEFAULT = 32;
  localparam int          LW_W          = 6;
  localparam logic [5:0]  WIDTH_RESET   = 6'd10;
  localparam int          QUEUE_DEPTH   = 2;

  localparam logic [7:0]  CH_SPACE      = 8'd32;
  localparam logic [7:0]  CH_TAB        = 8'd9;
  localparam logic [7:0]  CH_NL         = 8'd10;

  typedef enum logic [1:0] {
    KIND_EOT,
    KIND_NL,
    KIND_BLANK,
    KIND_CHAR
  } blf_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEND,
    S_NL,
    S_CRD,
    S_CWR
  } blf_state_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } blf_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_of_run;
  } blf_out_t;

  typedef struct packed {
    logic [7:0] ch;
    blf_kind_e  kind;
  } blf_cls_t;

endpackage

FILE: rtl/blf_front.sv
// ----------------------------------------------------------------------------
// blf_front
// Accepts input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module blf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  blf_pkg::blf_in_t  in_data_i,
  output logic              q_valid_o,
  output blf_pkg::blf_cls_t q_data_o,
  input  logic              q_pop_i
);

  localparam int QD   = blf_pkg::QUEUE_DEPTH;
  localparam int QP_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int QC_W = $clog2(QD + 1);

  blf_pkg::blf_cls_t entry_q [QD];
  logic [QP_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QC_W-1:0]   count_q, count_d;
  blf_pkg::blf_cls_t cls;
  logic              push;

  always_comb begin
    cls.ch = in_data_i.char_in;
    if (in_data_i.end_of_text) begin
      cls.kind = blf_pkg::KIND_EOT;
    end else if (in_data_i.char_in == blf_pkg::CH_NL) begin
      cls.kind = blf_pkg::KIND_NL;
    end else if (in_data_i.char_in inside {blf_pkg::CH_SPACE, blf_pkg::CH_TAB}) begin
      cls.kind = blf_pkg::KIND_BLANK;
    end else begin
      cls.kind = blf_pkg::KIND_CHAR;
    end
  end

  assign in_stall_o = (count_q == QC_W'(QD));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign q_data_o   = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == QP_W'(QD - 1)) ? '0 : wptr_q + QP_W'(1);
    end
    if (q_pop_i) begin
      rptr_d = (rptr_q == QP_W'(QD - 1)) ? '0 : rptr_q + QP_W'(1);
    end
    if (push && !q_pop_i) begin
      count_d = count_q + QC_W'(1);
    end else if (!push && q_pop_i) begin
      count_d = count_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= cls;
    end
  end

endmodule

FILE: rtl/blf_back.sv
// ----------------------------------------------------------------------------
// blf_back
// Line store, folding sequencer and output register.
// ----------------------------------------------------------------------------
module blf_back #(
  parameter int  BUFFER_DEPTH = blf_pkg::DEPTH_DEFAULT,
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1),
  localparam int AW           = $clog2(BUFFER_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  weff_i,
  input  logic              q_valid_i,
  input  blf_pkg::blf_cls_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output blf_pkg::blf_out_t out_data_o
);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rdata_q;

  blf_pkg::blf_state_e state_q, state_d;

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [AW-1:0]    lbp_q, lbp_d;
  logic             bs_q, bs_d;
  logic             at_q, at_d;
  logic             pb_q, pb_d;

  logic [CNT_W-1:0] idx_q, idx_d, len_q, len_d;
  logic             nl_q, nl_d;
  logic [CNT_W-1:0] src_q, src_d, dst_q, dst_d, cnt_q, cnt_d;

  logic             out_valid_q;
  blf_pkg::blf_out_t out_q;
  logic             slot_free;

  // item decode
  logic             store;
  logic [CNT_W-1:0] f1;
  logic [AW-1:0]    lbp1;
  logic             bs1, pb1;
  logic [CNT_W-1:0] rest;

  logic             mem_we, mem_re, out_load;
  logic [AW-1:0]    waddr, raddr;
  logic [7:0]       wdata;
  blf_pkg::blf_out_t out_new;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    store = 1'b0;
    case (q_data_i.kind)
      blf_pkg::KIND_CHAR:  store = 1'b1;
      blf_pkg::KIND_BLANK: store = !(at_q || pb_q);
      default:             store = 1'b0;
    endcase
    f1   = fill_q;
    lbp1 = lbp_q;
    bs1  = bs_q;
    pb1  = pb_q;
    if (fill_q < CNT_W'(BUFFER_DEPTH)) begin
      f1 = fill_q + CNT_W'(1);
      if (q_data_i.kind == blf_pkg::KIND_BLANK) begin
        lbp1 = fill_q[AW-1:0];
        bs1  = 1'b1;
        pb1  = 1'b1;
      end else begin
        pb1 = 1'b0;
      end
    end
    rest = f1 - CNT_W'(lbp1) - CNT_W'(1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    lbp_d   = lbp_q;
    bs_d    = bs_q;
    at_d    = at_q;
    pb_d    = pb_q;
    idx_d   = idx_q;
    len_d   = len_q;
    nl_d    = nl_q;
    src_d   = src_q;
    dst_d   = dst_q;
    cnt_d   = cnt_q;
    case (state_q)
      blf_pkg::S_IDLE: begin
        if (q_valid_i) begin
          idx_d = '0;
          len_d = '0;
          nl_d  = 1'b0;
          cnt_d = '0;
          dst_d = '0;
          if (q_data_i.kind inside {blf_pkg::KIND_EOT, blf_pkg::KIND_NL}) begin
            len_d  = fill_q;
            nl_d   = (q_data_i.kind == blf_pkg::KIND_NL);
            fill_d = '0;
            lbp_d  = '0;
            bs_d   = 1'b0;
            at_d   = 1'b1;
            pb_d   = 1'b0;
          end else if (store) begin
            fill_d = f1;
            lbp_d  = lbp1;
            bs_d   = bs1;
            pb_d   = pb1;
            at_d   = 1'b0;
            if (f1 >= weff_i) begin
              nl_d  = 1'b1;
              lbp_d = '0;
              bs_d  = 1'b0;
              pb_d  = 1'b0;
              if (bs1) begin
                len_d = CNT_W'(lbp1);
                src_d = CNT_W'(lbp1) + CNT_W'(1);
                cnt_d = rest;
                fill_d = rest;
                at_d  = (rest == '0);
              end else begin
                len_d  = f1;
                fill_d = '0;
                at_d   = 1'b1;
              end
            end
          end
          if (len_d != '0) begin
            state_d = blf_pkg::S_READ;
          end else if (nl_d) begin
            state_d = blf_pkg::S_NL;
          end
        end
      end
      blf_pkg::S_READ: state_d = blf_pkg::S_SEND;
      blf_pkg::S_SEND: begin
        if (slot_free) begin
          idx_d = idx_q + CNT_W'(1);
          if (idx_d != len_q) begin
            state_d = blf_pkg::S_READ;
          end else if (nl_q) begin
            state_d = blf_pkg::S_NL;
          end else begin
            state_d = blf_pkg::S_IDLE;
          end
        end
      end
      blf_pkg::S_NL: begin
        if (slot_free) begin
          state_d = (cnt_q != '0) ? blf_pkg::S_CRD : blf_pkg::S_IDLE;
        end
      end
      blf_pkg::S_CRD: state_d = blf_pkg::S_CWR;
      blf_pkg::S_CWR: begin
        src_d   = src_q + CNT_W'(1);
        dst_d   = dst_q + CNT_W'(1);
        cnt_d   = cnt_q - CNT_W'(1);
        state_d = (cnt_q == CNT_W'(1)) ? blf_pkg::S_IDLE : blf_pkg::S_CRD;
      end
      default: state_d = blf_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    waddr    = fill_q[AW-1:0];
    wdata    = q_data_i.ch;
    raddr    = idx_q[AW-1:0];
    out_load = 1'b0;
    out_new.char_out    = rdata_q;
    out_new.last_of_run = 1'b0;
    case (state_q)
      blf_pkg::S_IDLE: begin
        q_pop_o = q_valid_i;
        mem_we  = q_valid_i && store && (fill_q < CNT_W'(BUFFER_DEPTH));
      end
      blf_pkg::S_READ: mem_re = 1'b1;
      blf_pkg::S_SEND: begin
        out_load = slot_free;
        out_new.last_of_run = ((idx_q + CNT_W'(1)) == len_q) && !nl_q;
      end
      blf_pkg::S_NL: begin
        out_load = slot_free;
        out_new.char_out    = blf_pkg::CH_NL;
        out_new.last_of_run = 1'b1;
      end
      blf_pkg::S_CRD: begin
        mem_re = 1'b1;
        raddr  = src_q[AW-1:0];
      end
      blf_pkg::S_CWR: begin
        mem_we = 1'b1;
        waddr  = dst_q[AW-1:0];
        wdata  = rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blf_pkg::S_IDLE;
      fill_q      <= '0;
      lbp_q       <= '0;
      bs_q        <= 1'b0;
      at_q        <= 1'b1;
      pb_q        <= 1'b0;
      idx_q       <= '0;
      len_q       <= '0;
      nl_q        <= 1'b0;
      src_q       <= '0;
      dst_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      lbp_q   <= lbp_d;
      bs_q    <= bs_d;
      at_q    <= at_d;
      pb_q    <= pb_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      nl_q    <= nl_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(BUFFER_DEPTH))
    else $error("fill count beyond store depth");
  a_send_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == blf_pkg::S_SEND && !slot_free) |=>
      (state_q == blf_pkg::S_SEND && $stable(idx_q)))
    else $error("send step left while output blocked");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == blf_pkg::S_IDLE && q_valid_i))
    else $error("queue popped outside idle");
  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == blf_pkg::S_CRD || state_q == blf_pkg::S_CWR) |-> (cnt_q != '0))
    else $error("copy step with nothing to move");
`endif

endmodule

FILE: rtl/blank_aware_line_folder.sv
// ----------------------------------------------------------------------------
// blank_aware_line_folder
// Folds a byte stream into lines no longer than the width, clamped 2..depth.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | blf_in_t
//   out     | output    | out_valid_o/out_stall_i | blf_out_t
//   cfg     | input     | cfg_we_i             | cfg_wdata_i (line width)
//
// The back sequencer takes a stored or dropped byte in its idle state; an
// emitted byte passes a registered line store read, then the output register,
// an inserted newline only the output register, and a byte moved to the front
// after a fold is read, then written back. The line store is never read and
// written in the same state. No clearing pass after reset. Output stalls hold
// the sequencer; the input queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module blank_aware_line_folder #(
  parameter int BUFFER_DEPTH = blf_pkg::DEPTH_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  blf_pkg::blf_in_t        in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output blf_pkg::blf_out_t       out_data_o,
  input  logic                    cfg_we_i,
  input  logic [blf_pkg::LW_W-1:0] cfg_wdata_i
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int WC    = (CNT_W > blf_pkg::LW_W) ? CNT_W : blf_pkg::LW_W;

  logic [blf_pkg::LW_W-1:0] width_q;
  logic [WC-1:0]            width_ext;
  logic [CNT_W-1:0]         weff;
  logic                     q_valid, q_pop;
  blf_pkg::blf_cls_t        q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= blf_pkg::WIDTH_RESET;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  assign width_ext = WC'(width_q);

  always_comb begin
    if (width_ext < WC'(2)) begin
      weff = CNT_W'(2);
    end else if (width_ext > WC'(BUFFER_DEPTH)) begin
      weff = CNT_W'(BUFFER_DEPTH);
    end else begin
      weff = width_ext[CNT_W-1:0];
    end
  end

  blf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  blf_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .weff_i      (weff),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/sv/blank_aware_line_folder_tb.sv
// ----------------------------------------------------------------------------
// blank_aware_line_folder_tb
// Self-checking bench for the line folder. A short table of text bytes hits
// blank dropping, newline and end-of-text flushes, folds and the reset
// width. Random word-like text then runs under six width settings, from the
// saturating extremes to a random one, with sender gaps and receiver stalls
// in all but the last two. Output is checked against the table or a predictor.
// ----------------------------------------------------------------------------
module blank_aware_line_folder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = blf_pkg::DEPTH_DEFAULT;
  localparam int N_DIRECTED    = 25;
  localparam int N_SEGMENTS    = 6;
  localparam int SEG_WORDS     = 60;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct packed {
    blf_pkg::blf_in_t word;
    logic             typed;
    logic [2:0]       n;
    logic [39:0]      chars;
  } dir_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  blf_pkg::blf_in_t          in_data_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  blf_pkg::blf_out_t         out_data_o;
  logic                      cfg_we_i;
  logic [blf_pkg::LW_W-1:0]  cfg_wdata_i;

  blank_aware_line_folder #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // folding predictor state
  logic [7:0]               line_q [DEPTH];
  int unsigned              fill_n;
  int unsigned              blank_pos;
  bit                       have_blank;
  bit                       line_start;
  bit                       prev_blank;
  logic [blf_pkg::LW_W-1:0] width_reg;

  blf_pkg::blf_out_t        fold_out [$];
  blf_pkg::blf_out_t        expected_words [$];
  blf_pkg::blf_out_t        want;

  dir_row_t                 directed [N_DIRECTED];
  logic [blf_pkg::LW_W-1:0] seg_width [N_SEGMENTS];
  blf_pkg::blf_in_t         text_word;
  int              word_left = 0;
  int              gap_pct = 0;
  int              stall_pct = 0;
  int              errors = 0;
  int              words_sent = 0;
  int              words_checked = 0;
  int              widths_used = 0;
  int              quiet_cycles = 0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic bit is_blank(input logic [7:0] ch);
    return ch inside {blf_pkg::CH_SPACE, blf_pkg::CH_TAB};
  endfunction

  function automatic dir_row_t row(input logic [7:0] ch, input logic eot, input logic typed,
                                   input logic [2:0] n, input logic [39:0] chars);
    dir_row_t r;
    r.word.char_in     = ch;
    r.word.end_of_text = eot;
    r.typed            = typed;
    r.n                = n;
    r.chars            = chars;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic push_char(input logic [7:0] ch);
    blf_pkg::blf_out_t o;
    o.char_out    = ch;
    o.last_of_run = 1'b0;
    fold_out.push_back(o);
  endtask

  task automatic push_line(input int unsigned len);
    for (int unsigned i = 0; i < len && i < DEPTH; i++) push_char(line_q[i]);
  endtask

  task automatic back_to_start();
    fill_n     = 0;
    have_blank = 1'b0;
    blank_pos  = 0;
    line_start = 1'b1;
    prev_blank = 1'b0;
  endtask

  task automatic fold_predict(input blf_pkg::blf_in_t w);
    int unsigned lim;
    int unsigned keep_from;
    int unsigned keep_n;
    lim = 32'(width_reg);
    if (lim < 2) lim = 2;
    if (lim > DEPTH) lim = DEPTH;
    fold_out.delete();
    if (w.end_of_text) begin
      push_line(fill_n);
      back_to_start();
    end else if (w.char_in == blf_pkg::CH_NL) begin
      push_line(fill_n);
      push_char(blf_pkg::CH_NL);
      back_to_start();
    end else if (!(is_blank(w.char_in) && (line_start || prev_blank))) begin
      if (fill_n < DEPTH) begin
        line_q[fill_n] = w.char_in;
        prev_blank = is_blank(w.char_in);
        if (prev_blank) begin
          blank_pos  = fill_n;
          have_blank = 1'b1;
        end
        fill_n++;
      end
      line_start = 1'b0;
      if (fill_n >= lim) begin
        if (have_blank && blank_pos < fill_n) begin
          keep_from = blank_pos + 1;
          keep_n    = fill_n - keep_from;
          push_line(blank_pos);
          push_char(blf_pkg::CH_NL);
          for (int unsigned i = 0; i < keep_n; i++) line_q[i] = line_q[keep_from + i];
          if (keep_n == 0) begin
            back_to_start();
          end else begin
            fill_n     = keep_n;
            have_blank = 1'b0;
            blank_pos  = 0;
            line_start = 1'b0;
            prev_blank = 1'b0;
          end
        end else begin
          push_line(fill_n);
          push_char(blf_pkg::CH_NL);
          back_to_start();
        end
      end
    end
    if (fold_out.size() > 0) fold_out[fold_out.size() - 1].last_of_run = 1'b1;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input blf_pkg::blf_in_t w, input bit typed, input int n,
                           input logic [39:0] chars);
    blf_pkg::blf_out_t o;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    fold_predict(w);
    if (typed) begin
      for (int i = 0; i < n; i++) begin
        o.char_out    = chars[8*i +: 8];
        o.last_of_run = (i == n - 1);
        expected_words.push_back(o);
      end
    end else begin
      foreach (fold_out[i]) expected_words.push_back(fold_out[i]);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic write_width(input logic [blf_pkg::LW_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    width_reg = v;
    widths_used++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // word-like text with blank runs, newlines, flushes and raw bytes
  task automatic next_text_word(output blf_pkg::blf_in_t w);
    int r;
    w.end_of_text = 1'b0;
    if (word_left > 0) begin
      word_left--;
      if ($urandom_range(0, 9) == 0) w.char_in = 8'($urandom_range(8'h30, 8'h39));
      else w.char_in = 8'($urandom_range(8'h61, 8'h7a));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 7) begin
        w.char_in = blf_pkg::CH_NL;
      end else if (r < 12) begin
        w.char_in     = 8'($urandom);
        w.end_of_text = 1'b1;
      end else if (r < 20) begin
        w.char_in = 8'($urandom);
      end else begin
        w.char_in = ($urandom_range(0, 3) == 0) ? blf_pkg::CH_TAB : blf_pkg::CH_SPACE;
        if (r >= 36) word_left = $urandom_range(1, 8);
        else if (r >= 30) word_left = $urandom_range(18, 40);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("output word 0x%02h with nothing expected",
                                out_data_o.char_out));
      end else begin
        want = expected_words.pop_front();
        if (out_data_o.char_out !== want.char_out)
          flag_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
                                  out_data_o.char_out, want.char_out));
        if (out_data_o.last_of_run !== want.last_of_run)
          flag_mismatch($sformatf("last_of_run %0b, expected %0b on char 0x%02h",
                                  out_data_o.last_of_run, want.last_of_run, want.char_out));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_words.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    for (int i = 0; i < DEPTH; i++) line_q[i] = 8'h00;
    back_to_start();
    width_reg = blf_pkg::WIDTH_RESET;

    // reset width 10; chars listed first byte lowest
    directed[0]  = row(8'h00,            1'b1, 1'b1, 3'd0, 40'h0);
    directed[1]  = row(blf_pkg::CH_NL,    1'b0, 1'b1, 3'd1, 40'h0a);
    directed[2]  = row(blf_pkg::CH_SPACE, 1'b0, 1'b1, 3'd0, 40'h0);
    directed[3]  = row(blf_pkg::CH_TAB,   1'b0, 1'b1, 3'd0, 40'h0);
    directed[4]  = row("a",              1'b0, 1'b1, 3'd0, 40'h0);
    directed[5]  = row(blf_pkg::CH_SPACE, 1'b0, 1'b1, 3'd0, 40'h0);
    directed[6]  = row(blf_pkg::CH_SPACE, 1'b0, 1'b1, 3'd0, 40'h0);
    directed[7]  = row(blf_pkg::CH_TAB,   1'b0, 1'b1, 3'd0, 40'h0);
    directed[8]  = row("b",              1'b0, 1'b1, 3'd0, 40'h0);
    directed[9]  = row(blf_pkg::CH_SPACE, 1'b0, 1'b1, 3'd0, 40'h0);
    directed[10] = row(blf_pkg::CH_NL,    1'b0, 1'b1, 3'd5, 40'h0a_20_62_20_61);
    directed[11] = row(8'hff,            1'b0, 1'b1, 3'd0, 40'h0);
    directed[12] = row(8'h00,            1'b0, 1'b1, 3'd0, 40'h0);
    directed[13] = row(blf_pkg::CH_NL,    1'b1, 1'b1, 3'd2, 40'h00_ff);
    directed[14] = row(8'hff,            1'b1, 1'b1, 3'd0, 40'h0);
    directed[15] = row("a",              1'b0, 1'b0, 3'd0, 40'h0);
    directed[16] = row("b",              1'b0, 1'b0, 3'd0, 40'h0);
    directed[17] = row(blf_pkg::CH_SPACE, 1'b0, 1'b0, 3'd0, 40'h0);
    directed[18] = row("c",              1'b0, 1'b0, 3'd0, 40'h0);
    directed[19] = row("d",              1'b0, 1'b0, 3'd0, 40'h0);
    directed[20] = row("e",              1'b0, 1'b0, 3'd0, 40'h0);
    directed[21] = row("f",              1'b0, 1'b0, 3'd0, 40'h0);
    directed[22] = row("g",              1'b0, 1'b0, 3'd0, 40'h0);
    directed[23] = row("h",              1'b0, 1'b0, 3'd0, 40'h0);
    directed[24] = row("i",              1'b0, 1'b0, 3'd0, 40'h0);

    // leftover text from the table meets a narrowed width first
    seg_width[0] = 6'd1;
    seg_width[1] = 6'd63;
    seg_width[2] = 6'd2;
    seg_width[3] = 6'd32;
    seg_width[4] = 6'd0;
    seg_width[5] = 6'($urandom_range(3, 31));

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    gap_pct   = 16;
    stall_pct = 63;
    for (int i = 0; i < N_DIRECTED; i++)
      send_word(directed[i].word, directed[i].typed, int'(directed[i].n), directed[i].chars);

    for (int s = 0; s < N_SEGMENTS; s++) begin
      wait_results_done();
      repeat (SETTLE_CYCLES) @(negedge clk_i);
      if (s < 2) begin
        gap_pct   = 16;
        stall_pct = 63;
      end else if (s < 4) begin
        gap_pct   = 63;
        stall_pct = 16;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      write_width(seg_width[s]);
      for (int k = 0; k < SEG_WORDS; k++) begin
        if (s == 2 && k == SEG_WORDS / 2) wait_results_done();
        next_text_word(text_word);
        send_word(text_word, 1'b0, 0, 40'h0);
      end
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("folded %0d input words into %0d checked output words", words_sent,
             words_checked);
    $display("reset width plus %0d programmed widths, saturating extremes included",
             widths_used);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/blf_pkg.sv
rtl/blf_front.sv
rtl/blf_back.sv
rtl/blank_aware_line_folder.sv
tb/sv/blank_aware_line_folder_tb.sv
